### hw/rtl/tqv_pkg.sv
package tqv_pkg;

	// field widths
	localparam int TqvValueW   = 16;
	localparam int TqvCoordW   = 8;
	localparam int TqvRegW     = 9;
	localparam int TqvTexW     = 13;
	localparam int TqvSlotW    = 18;
	localparam int TqvPosW     = 17;
	localparam int TqvUvW      = 24;
	localparam int TqvCornerW  = 2;
	localparam int TqvCfgIdxW  = 2;
	localparam int TqvCfgDataW = 13;

	// map bounds
	localparam int TqvMaxColumns = 256;
	localparam int TqvMaxRows    = 256;
	localparam int TqvBoundW     = 14;

	// tileset index divider
	localparam int TqvIndexW    = 15;
	localparam int TqvRemW      = 13;
	localparam int TqvPerRowW   = 13;
	localparam int TqvDivSteps  = 3;
	localparam int TqvDivStages = TqvIndexW / TqvDivSteps;

	// register indexes
	localparam logic [TqvCfgIdxW-1:0] TqvCfgMapColumns   = 2'd0;
	localparam logic [TqvCfgIdxW-1:0] TqvCfgTileWidth    = 2'd1;
	localparam logic [TqvCfgIdxW-1:0] TqvCfgTileHeight   = 2'd2;
	localparam logic [TqvCfgIdxW-1:0] TqvCfgTextureWidth = 2'd3;

	// corner codes
	localparam logic [TqvCornerW-1:0] TqvCornerTl = 2'd0;
	localparam logic [TqvCornerW-1:0] TqvCornerTr = 2'd1;
	localparam logic [TqvCornerW-1:0] TqvCornerBr = 2'd2;
	localparam logic [TqvCornerW-1:0] TqvCornerBl = 2'd3;

	typedef struct packed {
		logic [TqvRemW-1:0]   rem;
		logic [TqvIndexW-1:0] num;
	} tqv_div_t;

	// one restoring step: quotient bits shift into num from the bottom
	function automatic tqv_div_t tqv_div_step(tqv_div_t cur, logic [TqvPerRowW-1:0] divisor);
		logic [TqvRemW:0] rem_sh;
		tqv_div_t         nxt;
		rem_sh  = {cur.rem, cur.num[TqvIndexW-1]};
		nxt.num = {cur.num[TqvIndexW-2:0], 1'b0};
		nxt.rem = rem_sh[TqvRemW-1:0];
		if (rem_sh >= divisor) begin
			nxt.rem    = TqvRemW'(rem_sh - divisor);
			nxt.num[0] = 1'b1;
		end
		return nxt;
	endfunction

endpackage

### hw/rtl/tqv_div_stage.sv
module tqv_div_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  tqv_pkg::tqv_div_t                   in_data,
	input  logic [tqv_pkg::TqvPerRowW-1:0]      divisor,
	output logic                                out_valid,
	output tqv_pkg::tqv_div_t                   out_data
);

	tqv_pkg::tqv_div_t step_d [tqv_pkg::TqvDivSteps+1];
	logic              valid_s1;
	tqv_pkg::tqv_div_t data_s1;

	always_comb begin
		step_d[0] = in_data;
		for (int i = 0; i < tqv_pkg::TqvDivSteps; i++) begin
			step_d[i+1] = tqv_pkg::tqv_div_step(step_d[i], divisor);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= step_d[tqv_pkg::TqvDivSteps];
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### hw/rtl/tile_quad_vertex_generator.sv
// A tile passes stage 1, divider stages 2 to 6, stage 7 and the quad register before its first
// vertex beat on the master side. A non-empty tile holds the pipe while the quad register sends
// its four vertex beats; empty or dropped tiles pass at one per cycle when no quad is being sent.
// Seven pipeline stages then a quad register. A write to tile_width or texture_width runs a serial
// divide for tiles per row with s_tready low. Reset loads the register defaults and empties the pipe.
module tile_quad_vertex_generator #(
	parameter int MaxColumns = tqv_pkg::TqvMaxColumns,
	parameter int MaxRows    = tqv_pkg::TqvMaxRows
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // tile_value[15:0], tile_column[23:16], tile_row[31:24]
	output logic         m_tvalid,
	input  logic         m_tready,
	// vertex_slot[17:0], screen_x[34:18], screen_y[51:35], texture_u[75:52],
	// texture_v[99:76], zero[103:100]
	output logic [103:0] m_tdata,
	output logic [1:0]   m_tuser,   // corner[1:0]
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [tqv_pkg::TqvCfgIdxW-1:0]  cfg_index,
	input  logic [tqv_pkg::TqvCfgDataW-1:0] cfg_data
);

	localparam int Stages = tqv_pkg::TqvDivStages;

	typedef struct packed {
		logic [15:0]                  slot;
		logic [tqv_pkg::TqvPosW-1:0]  sx;
		logic [tqv_pkg::TqvPosW-1:0]  sy;
	} tqv_side_t;

	// configuration
	logic [tqv_pkg::TqvRegW-1:0]    map_columns_q;
	logic [tqv_pkg::TqvRegW-1:0]    tile_width_q;
	logic [tqv_pkg::TqvRegW-1:0]    tile_height_q;
	logic [tqv_pkg::TqvTexW-1:0]    texture_width_q;
	logic [tqv_pkg::TqvPerRowW-1:0] per_row_q;
	logic                           cdiv_start_q;
	logic [3:0]                     cdiv_cnt_q;
	logic [tqv_pkg::TqvRegW:0]      cdiv_rem_q;
	logic [tqv_pkg::TqvTexW-1:0]    cdiv_num_q;
	logic [tqv_pkg::TqvRegW:0]      cdiv_sh;
	logic                           cdiv_ge;
	logic [tqv_pkg::TqvTexW-1:0]    cdiv_num_nxt;
	logic                           cdiv_busy;
	logic                           cfg_beat;

	// input decode
	logic [tqv_pkg::TqvValueW-1:0] in_value;
	logic [tqv_pkg::TqvCoordW-1:0] in_col;
	logic [tqv_pkg::TqvCoordW-1:0] in_row;
	logic                          in_keep;
	logic                          s_beat;
	logic                          en;

	// stage 1
	logic                           valid_s1;
	tqv_pkg::tqv_div_t              div_s1;
	logic [tqv_pkg::TqvCoordW-1:0]  col_s1;
	logic [tqv_pkg::TqvPosW-1:0]    rowmc_s1;
	logic [tqv_pkg::TqvPosW-1:0]    sx_s1;
	logic [tqv_pkg::TqvPosW-1:0]    sy_s1;

	// divider chain, stages 2 to 6
	logic              div_valid [Stages+1];
	tqv_pkg::tqv_div_t div_data  [Stages+1];
	tqv_side_t         side_s2, side_s3, side_s4, side_s5, side_s6;

	// stage 7
	logic                          valid_s7;
	tqv_side_t                     side_s7;
	logic [tqv_pkg::TqvUvW-1:0]    u_s7;
	logic [tqv_pkg::TqvUvW-1:0]    v_s7;

	// quad register
	logic                            quad_valid_q;
	logic [tqv_pkg::TqvCornerW-1:0]  corner_q;
	tqv_side_t                       quad_side_q;
	logic [tqv_pkg::TqvUvW-1:0]      quad_u_q;
	logic [tqv_pkg::TqvUvW-1:0]      quad_v_q;
	logic                            right;
	logic                            bottom;
	logic [tqv_pkg::TqvPosW-1:0]     out_sx;
	logic [tqv_pkg::TqvPosW-1:0]     out_sy;
	logic [tqv_pkg::TqvUvW-1:0]      out_u;
	logic [tqv_pkg::TqvUvW-1:0]      out_v;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_beat  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_columns_q   <= 9'd1;
			tile_width_q    <= 9'd16;
			tile_height_q   <= 9'd16;
			texture_width_q <= 13'd256;
		end else if (cfg_beat) begin
			unique case (cfg_index)
				tqv_pkg::TqvCfgMapColumns:   map_columns_q   <= cfg_data[tqv_pkg::TqvRegW-1:0];
				tqv_pkg::TqvCfgTileWidth:    tile_width_q    <= cfg_data[tqv_pkg::TqvRegW-1:0];
				tqv_pkg::TqvCfgTileHeight:   tile_height_q   <= cfg_data[tqv_pkg::TqvRegW-1:0];
				tqv_pkg::TqvCfgTextureWidth: texture_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tiles per row = texture_width / tile_width, one quotient bit per cycle
	assign cdiv_sh      = {cdiv_rem_q[tqv_pkg::TqvRegW-1:0], cdiv_num_q[tqv_pkg::TqvTexW-1]};
	assign cdiv_ge      = cdiv_sh >= {1'b0, tile_width_q};
	assign cdiv_num_nxt = {cdiv_num_q[tqv_pkg::TqvTexW-2:0], cdiv_ge};
	assign cdiv_busy    = cdiv_start_q || (cdiv_cnt_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdiv_start_q <= 1'b0;
			cdiv_cnt_q   <= 4'd0;
			per_row_q    <= 13'd16;
		end else begin
			cdiv_start_q <= cfg_beat && (cfg_index == tqv_pkg::TqvCfgTileWidth
				|| cfg_index == tqv_pkg::TqvCfgTextureWidth);
			if (cdiv_start_q) begin
				cdiv_cnt_q <= 4'(tqv_pkg::TqvTexW);
			end else if (cdiv_cnt_q != 4'd0) begin
				cdiv_cnt_q <= cdiv_cnt_q - 4'd1;
				if (cdiv_cnt_q == 4'd1) begin
					per_row_q <= cdiv_num_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cdiv_start_q) begin
			cdiv_rem_q <= '0;
			cdiv_num_q <= texture_width_q;
		end else if (cdiv_cnt_q != 4'd0) begin
			cdiv_rem_q <= cdiv_ge ? (cdiv_sh - {1'b0, tile_width_q}) : cdiv_sh;
			cdiv_num_q <= cdiv_num_nxt;
		end
	end

	// ---------------- input and stage 1 ----------------
	assign en       = !quad_valid_q || (m_tready && corner_q == tqv_pkg::TqvCornerBl);
	assign s_tready = en && !cdiv_busy;
	assign s_beat   = s_tvalid && s_tready;

	assign in_value = s_tdata[15:0];
	assign in_col   = s_tdata[23:16];
	assign in_row   = s_tdata[31:24];

	// drop empty or negative entries, a zero tile width, a texture narrower than a tile and tiles outside the map
	assign in_keep = !in_value[tqv_pkg::TqvValueW-1] && (in_value != '0)
		&& (tile_width_q != '0) && (texture_width_q >= {4'd0, tile_width_q})
		&& ({1'b0, in_col} < map_columns_q)
		&& ({6'd0, in_col} < tqv_pkg::TqvBoundW'(MaxColumns))
		&& ({6'd0, in_row} < tqv_pkg::TqvBoundW'(MaxRows));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_beat && in_keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1.rem <= '0;
			div_s1.num <= tqv_pkg::TqvIndexW'(in_value - 16'd1);
			col_s1     <= in_col;
			rowmc_s1   <= {9'd0, in_row} * {8'd0, map_columns_q};
			sx_s1      <= {9'd0, in_col} * {8'd0, tile_width_q};
			sy_s1      <= {9'd0, in_row} * {8'd0, tile_height_q};
		end
	end

	// ---------------- index divide, stages 2 to 6 ----------------
	assign div_valid[0] = valid_s1;
	assign div_data[0]  = div_s1;

	for (genvar g = 0; g < Stages; g++) begin : g_div
		tqv_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_valid[g]),
			.in_data   (div_data[g]),
			.divisor   (per_row_q),
			.out_valid (div_valid[g+1]),
			.out_data  (div_data[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.slot <= 16'(rowmc_s1 + {9'd0, col_s1});
			side_s2.sx   <= sx_s1;
			side_s2.sy   <= sy_s1;
			side_s3      <= side_s2;
			side_s4      <= side_s3;
			side_s5      <= side_s4;
			side_s6      <= side_s5;
		end
	end

	// ---------------- stage 7: texture origin ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= div_valid[Stages];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			u_s7    <= {11'd0, div_data[Stages].rem} * {15'd0, tile_width_q};
			v_s7    <= {9'd0, div_data[Stages].num} * {15'd0, tile_height_q};
		end
	end

	// ---------------- quad register, four beats per tile ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_valid_q <= 1'b0;
			corner_q     <= tqv_pkg::TqvCornerTl;
		end else if (en) begin
			quad_valid_q <= valid_s7;
			corner_q     <= tqv_pkg::TqvCornerTl;
		end else if (m_tready) begin
			corner_q <= corner_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s7) begin
			quad_side_q <= side_s7;
			quad_u_q    <= u_s7;
			quad_v_q    <= v_s7;
		end
	end

	assign right  = (corner_q == tqv_pkg::TqvCornerTr) || (corner_q == tqv_pkg::TqvCornerBr);
	assign bottom = (corner_q == tqv_pkg::TqvCornerBr) || (corner_q == tqv_pkg::TqvCornerBl);

	assign out_sx = quad_side_q.sx + (right  ? {8'd0, tile_width_q}  : '0);
	assign out_sy = quad_side_q.sy + (bottom ? {8'd0, tile_height_q} : '0);
	assign out_u  = quad_u_q + (right  ? {15'd0, tile_width_q}  : '0);
	assign out_v  = quad_v_q + (bottom ? {15'd0, tile_height_q} : '0);

	assign m_tvalid = quad_valid_q;
	assign m_tdata  = {4'd0, out_v, out_u, out_sy, out_sx, quad_side_q.slot, corner_q};
	assign m_tuser  = corner_q;
	assign m_tlast  = corner_q == tqv_pkg::TqvCornerBl;

	// ---------------- assertions ----------------
	a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		cdiv_busy |-> !s_tready)
		else $error("tile accepted during tiles-per-row divide");

	a_corner_advance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == $past(m_tuser) + 2'd1))
		else $error("vertex corner did not advance by one");

	a_quad_starts_tl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tuser == tqv_pkg::TqvCornerTl))
		else $error("new quad did not start at the top-left corner");

	a_s7_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !en |=> valid_s7 && $stable(u_s7) && $stable(v_s7))
		else $error("stage 7 changed during a stall");

endmodule

### sim/tb_tile_quad_vertex_generator.sv
module tb_tile_quad_vertex_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit   = 500000;
	localparam int SettleCycles = 16;
	localparam int RandPhases   = 6;
	localparam int QuadsPerPhase = 36;
	localparam int ReportMax    = 10;

	typedef struct packed {
		logic [tqv_pkg::TqvSlotW-1:0]   slot;
		logic [tqv_pkg::TqvCornerW-1:0] corner;
		logic [tqv_pkg::TqvPosW-1:0]    sx;
		logic [tqv_pkg::TqvPosW-1:0]    sy;
		logic [tqv_pkg::TqvUvW-1:0]     u;
		logic [tqv_pkg::TqvUvW-1:0]     v;
		logic                           last;
	} vertex_t;

	typedef struct {
		logic [tqv_pkg::TqvCfgDataW-1:0] map_cols;
		logic [tqv_pkg::TqvCfgDataW-1:0] tile_w;
		logic [tqv_pkg::TqvCfgDataW-1:0] tile_h;
		logic [tqv_pkg::TqvCfgDataW-1:0] tex_w;
	} reg_set_t;

	typedef enum {EXP_MODEL, EXP_NONE, EXP_TOPLEFT} tile_check_t;

	typedef struct {
		int                             set;
		logic [tqv_pkg::TqvValueW-1:0]  value;
		logic [tqv_pkg::TqvCoordW-1:0]  col;
		logic [tqv_pkg::TqvCoordW-1:0]  row;
		tile_check_t                    chk;
		logic [tqv_pkg::TqvSlotW-1:0]   slot;
		logic [tqv_pkg::TqvPosW-1:0]    sx;
		logic [tqv_pkg::TqvPosW-1:0]    sy;
		logic [tqv_pkg::TqvUvW-1:0]     u;
		logic [tqv_pkg::TqvUvW-1:0]     v;
	} tile_case_t;

	localparam logic [tqv_pkg::TqvCfgIdxW-1:0] RegOrder[4] = '{
		tqv_pkg::TqvCfgMapColumns, tqv_pkg::TqvCfgTileWidth,
		tqv_pkg::TqvCfgTileHeight, tqv_pkg::TqvCfgTextureWidth
	};
	localparam logic [tqv_pkg::TqvCornerW-1:0] CornerOrder[4] = '{
		tqv_pkg::TqvCornerTl, tqv_pkg::TqvCornerTr, tqv_pkg::TqvCornerBr, tqv_pkg::TqvCornerBl
	};

	// set 0 is the reset state
	reg_set_t fixed_sets[6] = '{
		'{13'd1,   13'd16,  13'd16,  13'd256},
		'{13'd256, 13'd1,   13'd1,   13'd4096},
		'{13'd1,   13'd17,  13'd16,  13'd16},
		'{13'd1,   13'd0,   13'd16,  13'd256},
		'{13'd511, 13'd511, 13'd511, 13'd8191},
		'{13'd0,   13'd16,  13'd16,  13'd256}
	};

	tile_case_t tile_cases[23] = '{
		'{0, 16'h0001, 8'd0,   8'd0,   EXP_TOPLEFT, 18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'h0000, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'hFFFF, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'h8000, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'h7FFF, 8'd0,   8'd255, EXP_TOPLEFT, 18'd1020, 17'd0, 17'd4080,
			24'd224, 24'd32752},
		'{0, 16'h0001, 8'd1,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'h0001, 8'd255, 8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'h0011, 8'd0,   8'd3,   EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{0, 16'h0010, 8'd0,   8'd0,   EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{1, 16'h7FFF, 8'd255, 8'd255, EXP_TOPLEFT, 18'd262140, 17'd255, 17'd255,
			24'd4094, 24'd7},
		'{1, 16'h0001, 8'd255, 8'd0,   EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{1, 16'h1000, 8'd0,   8'd0,   EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{1, 16'h1001, 8'd3,   8'd4,   EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{1, 16'h5555, 8'hAA,  8'h55,  EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{1, 16'h2AAA, 8'h55,  8'hAA,  EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{2, 16'h0001, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{2, 16'h7FFF, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{3, 16'h0001, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{4, 16'h7FFF, 8'd255, 8'd255, EXP_TOPLEFT, 18'd260096, 17'd130305, 17'd130305,
			24'd7154, 24'd1046017},
		'{4, 16'h0002, 8'd0,   8'd0,   EXP_MODEL,   18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{5, 16'h0001, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{5, 16'h7FFF, 8'd255, 8'd255, EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0},
		'{5, 16'h0005, 8'd0,   8'd0,   EXP_NONE,    18'd0, 17'd0, 17'd0, 24'd0, 24'd0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [31:0]                     s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [103:0]                    m_tdata;
	logic [1:0]                      m_tuser;
	logic                            m_tlast;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [tqv_pkg::TqvCfgIdxW-1:0]  cfg_index = '0;
	logic [tqv_pkg::TqvCfgDataW-1:0] cfg_data = '0;

	// register copy seen by the predictor
	logic [tqv_pkg::TqvRegW-1:0] map_cols = 9'd1;
	logic [tqv_pkg::TqvRegW-1:0] tile_w   = 9'd16;
	logic [tqv_pkg::TqvRegW-1:0] tile_h   = 9'd16;
	logic [tqv_pkg::TqvTexW-1:0] tex_w    = 13'd256;

	vertex_t pending_vertices[$];
	int      errors = 0;
	int      cycle_count = 0;
	int      tiles_sent = 0;
	int      quads_sent = 0;
	int      vertices_seen = 0;
	int      settings_used = 1;

	tile_quad_vertex_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d vertices outstanding", cycle_count,
				pending_vertices.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= ReportMax)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			flag_error($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	// expand one tile beat into its quad; n is 0 or 4
	task automatic predict_quad(input logic [31:0] beat, output int n, output vertex_t top_left);
		logic signed [tqv_pkg::TqvValueW-1:0] value;
		int unsigned col, row, per_row, index, tu, tv, base, right, bottom;
		vertex_t vx;
		value = beat[15:0];
		col   = 32'(beat[23:16]);
		row   = 32'(beat[31:24]);
		n = 0;
		top_left = '0;
		if (value <= 0)
			return;
		if (tile_w == '0 || tex_w < {4'd0, tile_w})
			return;
		if (col >= 32'(map_cols) || col >= tqv_pkg::TqvMaxColumns
				|| row >= tqv_pkg::TqvMaxRows)
			return;
		per_row = 32'(tex_w) / 32'(tile_w);
		index   = 32'(beat[15:0]) - 32'd1;
		tu      = index % per_row;
		tv      = index / per_row;
		base    = (col + row * 32'(map_cols)) * 32'd4;
		for (int k = 0; k < 4; k++) begin
			right  = 32'(CornerOrder[k] == tqv_pkg::TqvCornerTr
				|| CornerOrder[k] == tqv_pkg::TqvCornerBr);
			bottom = 32'(CornerOrder[k] == tqv_pkg::TqvCornerBr
				|| CornerOrder[k] == tqv_pkg::TqvCornerBl);
			vx.slot   = tqv_pkg::TqvSlotW'(base + 32'(k));
			vx.corner = CornerOrder[k];
			vx.sx     = tqv_pkg::TqvPosW'((col + right) * 32'(tile_w));
			vx.sy     = tqv_pkg::TqvPosW'((row + bottom) * 32'(tile_h));
			vx.u      = tqv_pkg::TqvUvW'((tu + right) * 32'(tile_w));
			vx.v      = tqv_pkg::TqvUvW'((tv + bottom) * 32'(tile_h));
			vx.last   = (CornerOrder[k] == tqv_pkg::TqvCornerBl);
			if (k == 0)
				top_left = vx;
			pending_vertices.push_back(vx);
		end
		n = 4;
	endtask

	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_tile(input logic [31:0] beat, input int gap, output int n,
			output vertex_t top_left);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		do @(posedge clk); while (!s_tready);
		tiles_sent++;
		predict_quad(beat, n, top_left);
		if (n != 0)
			quads_sent++;
	endtask

	// drop valid, let the quads drain and the pipe empty of dropped tiles
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_regs(input reg_set_t s);
		int rot;
		logic [tqv_pkg::TqvCfgIdxW-1:0] idx;
		logic [tqv_pkg::TqvCfgDataW-1:0] val;
		rot = $urandom_range(0, 3);
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			idx = RegOrder[(i + rot) % 4];
			case (idx)
				tqv_pkg::TqvCfgMapColumns:   val = s.map_cols;
				tqv_pkg::TqvCfgTileWidth:    val = s.tile_w;
				tqv_pkg::TqvCfgTileHeight:   val = s.tile_h;
				default:                     val = s.tex_w;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			case (idx)
				tqv_pkg::TqvCfgMapColumns:   map_cols = val[tqv_pkg::TqvRegW-1:0];
				tqv_pkg::TqvCfgTileWidth:    tile_w   = val[tqv_pkg::TqvRegW-1:0];
				tqv_pkg::TqvCfgTileHeight:   tile_h   = val[tqv_pkg::TqvRegW-1:0];
				default:                     tex_w    = val;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// mostly in range, now and then zero, oversize or stray upper data bits
	function automatic logic [tqv_pkg::TqvCfgDataW-1:0] narrow_reg(input int lo);
		int r;
		logic [tqv_pkg::TqvCfgDataW-1:0] val;
		r = $urandom_range(0, 11);
		if (r == 0)
			val = 13'(lo);
		else if (r == 1)
			val = 13'($urandom_range(257, 511));
		else if (r == 2)
			val = 13'd256;
		else if (r < 6)
			val = 13'($urandom_range(1, 24));
		else
			val = 13'($urandom_range(1, 256));
		if ($urandom_range(0, 5) == 0)
			val[tqv_pkg::TqvCfgDataW-1:tqv_pkg::TqvRegW] = 4'($urandom);
		return val;
	endfunction

	task automatic random_regs(output reg_set_t s);
		int r;
		int tw;
		s.map_cols = narrow_reg(0);
		s.tile_w   = ($urandom_range(0, 15) == 0) ? 13'd0 : narrow_reg(1);
		s.tile_h   = narrow_reg(0);
		tw = int'(s.tile_w[tqv_pkg::TqvRegW-1:0]);
		r = $urandom_range(0, 9);
		if (r == 0)
			s.tex_w = 13'($urandom_range(0, tw));
		else if (r == 1)
			s.tex_w = 13'($urandom_range(4097, 8191));
		else if (r == 2)
			s.tex_w = 13'd4096;
		else
			s.tex_w = 13'($urandom_range(tw > 0 ? tw : 1, 4096));
	endtask

	function automatic logic [31:0] random_tile();
		int r;
		int lim;
		logic [tqv_pkg::TqvValueW-1:0] value;
		logic [tqv_pkg::TqvCoordW-1:0] col;
		r = $urandom_range(0, 99);
		if (r >= 88)
			return $urandom;
		if (r >= 78) begin
			value = (r < 81) ? 16'h0000 : {1'b1, 15'($urandom)};
			return {8'($urandom), 8'($urandom), value};
		end
		value = (r < 40) ? 16'($urandom_range(1, 300)) : 16'($urandom_range(1, 32767));
		lim = (int'(map_cols) > tqv_pkg::TqvMaxColumns) ? tqv_pkg::TqvMaxColumns
			: int'(map_cols);
		col = (lim == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
		return {8'($urandom), col, value};
	endfunction

	// output side: random stalls, short and long, with long ready runs
	initial begin : drive_sink
		int r;
		int len;
		repeat (4) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				m_tready <= 1'b1;
				len = $urandom_range(50, 150);
			end else if (r < 55) begin
				m_tready <= 1'b1;
				len = $urandom_range(1, 20);
			end else if (r < 90) begin
				m_tready <= 1'b0;
				len = $urandom_range(1, 3);
			end else begin
				m_tready <= 1'b0;
				len = $urandom_range(10, 30);
			end
			repeat (len) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_vertices
		vertex_t want;
		if (arst_n && m_tvalid && m_tready) begin
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				flag_error($sformatf("vertex beat with nothing expected: slot %0d corner %0d",
					m_tdata[17:0], m_tuser));
			end else begin
				want = pending_vertices.pop_front();
				check_field("vertex_slot", 32'(want.slot), 32'(m_tdata[17:0]));
				check_field("corner", 32'(want.corner), 32'(m_tuser));
				check_field("screen_x", 32'(want.sx), 32'(m_tdata[34:18]));
				check_field("screen_y", 32'(want.sy), 32'(m_tdata[51:35]));
				check_field("texture_u", 32'(want.u), 32'(m_tdata[75:52]));
				check_field("texture_v", 32'(want.v), 32'(m_tdata[99:76]));
				check_field("pad bits", 32'd0, 32'(m_tdata[103:100]));
				check_field("last_corner", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	initial begin : run_tiles
		int cur_set;
		int n;
		int hits;
		int tries;
		bit steady;
		vertex_t tl;
		vertex_t typed;
		reg_set_t rs;
		tile_case_t c;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		foreach (tile_cases[i]) begin
			c = tile_cases[i];
			if (c.set != cur_set) begin
				write_regs(fixed_sets[c.set]);
				cur_set = c.set;
			end
			send_tile({c.row, c.col, c.value}, pick_gap(1'b0), n, tl);
			typed = '{c.slot, tqv_pkg::TqvCornerTl, c.sx, c.sy, c.u, c.v, 1'b0};
			if (c.chk == EXP_NONE && n != 0)
				flag_error($sformatf("tile case %0d should give no quad", i));
			if (c.chk == EXP_TOPLEFT && (n != 4 || tl !== typed))
				flag_error($sformatf("tile case %0d top-left expected %h predicted %h",
					i, typed, tl));
		end

		for (int p = 0; p < RandPhases; p++) begin
			random_regs(rs);
			write_regs(rs);
			steady = (p == 0) || ($urandom_range(0, 3) == 0);
			hits = 0;
			tries = 0;
			// settings that drop everything end after a bounded number of tiles
			while (hits < QuadsPerPhase && tries < 3 * QuadsPerPhase) begin
				send_tile(random_tile(), pick_gap(steady), n, tl);
				tries++;
				if (n != 0)
					hits++;
			end
		end

		wait_idle();
		if (pending_vertices.size() != 0)
			flag_error($sformatf("%0d vertices never arrived", pending_vertices.size()));
		$display("covered %0d tiles (%0d quads), %0d vertex beats, %0d register settings",
			tiles_sent, quads_sent, vertices_seen, settings_used);
		$display("mismatches: %0d, cycles: %0d", errors, cycle_count);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
